// File: rtl/phy_packet_queue_with_skip_count_unit_macros.svh
// Assertion helpers used by the back end RTL file of the packet queue.
`ifndef PHY_PACKET_QUEUE_WITH_SKIP_COUNT_UNIT_MACROS_SVH
`define PHY_PACKET_QUEUE_WITH_SKIP_COUNT_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PPQSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked at every clock edge outside reset.
`define PPQSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/ppqsc_pkg.sv
`timescale 1ns / 1ps
package ppqsc_pkg;

  localparam logic CMD_PACKET     = 1'b0;
  localparam logic CMD_COMPLETION = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_SKIP = 1'b1;

  // Command queue between front and back
  localparam int FqDepth = 2;
  localparam int FqPtrW  = $clog2(FqDepth);
  localparam int FqCntW  = $clog2(FqDepth + 1);

  typedef struct packed {
    logic        command;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [3:0]  done_tag;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  tag;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic        is_cpl;
    logic [63:0] words;
    logic [3:0]  done_tag;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_e;

endpackage

// File: rtl/phy_packet_queue_with_skip_count_unit.sv
`timescale 1ns / 1ps
// Receive queue for two-word packets with one delivery outstanding at a time.
// Push packets and completions on the input side; deliveries appear on the
// result side. A transaction that causes no delivery leaves the back end
// idle; one that causes a delivery goes through the slot memory write, the
// registered read of the head slot and the load of the result register,
// waiting in the load while it is still full. A two-entry command queue in
// front absorbs bursts, so full rises only while the back end is busy. The
// slot memory holds QUEUE_DEPTH entries and needs no clearing after reset.
module phy_packet_queue_with_skip_count_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  ppqsc_pkg::in_item_t  in_item_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ppqsc_pkg::out_item_t out_item_o
);
  import ppqsc_pkg::*;

  logic [4:0] limit_q;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 5'd16;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  ppqsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  ppqsc_back #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/ppqsc_front.sv
`timescale 1ns / 1ps
module ppqsc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  ppqsc_pkg::in_item_t  in_item_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_pop_i,
  output ppqsc_pkg::cmd_t      cmd_o
);
  import ppqsc_pkg::*;

  in_item_t          fq_q [FqDepth];
  logic [FqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FqCntW-1:0] cnt_q, cnt_d;
  logic              push_ok;
  logic              pop_ok;
  in_item_t          head_item;

  assign full_o      = (cnt_q == FqCntW'(FqDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (int'(wr_ptr_q) == FqDepth - 1) ? '0 : wr_ptr_q + FqPtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (int'(rd_ptr_q) == FqDepth - 1) ? '0 : rd_ptr_q + FqPtrW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + FqCntW'(1);
      2'b01:   cnt_d = cnt_q - FqCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fq_q[wr_ptr_q] <= in_item_i;
    end
  end

  // Classify the oldest transaction for the back end
  assign head_item       = fq_q[rd_ptr_q];
  assign cmd_o.is_cpl    = (head_item.command == CMD_COMPLETION);
  assign cmd_o.words     = {head_item.second_word, head_item.first_word};
  assign cmd_o.done_tag  = head_item.done_tag;

endmodule

// File: rtl/ppqsc_back.sv
`timescale 1ns / 1ps
`include "phy_packet_queue_with_skip_count_unit_macros.svh"
module ppqsc_back #(
  parameter int QueueDepth = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           limit_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  ppqsc_pkg::cmd_t      cmd_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ppqsc_pkg::out_item_t out_item_o
);
  import ppqsc_pkg::*;

  localparam int PtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int MaxLimit = (QueueDepth < 31) ? QueueDepth : 31;
  localparam int CntW     = $clog2(MaxLimit + 1);

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (int'(p) == QueueDepth - 1) ? '0 : p + PtrW'(1);
  endfunction

  back_state_e       state_q, state_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [PtrW-1:0]   last_addr_q, last_addr_d;
  logic [CntW-1:0]   slots_q, slots_d;
  logic              outst_q, outst_d;
  logic              last_kind_q, last_kind_d;
  logic [31:0]       skip_cnt_q, skip_cnt_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic [64:0]       slot_mem_q [QueueDepth];
  logic [64:0]       rd_data_q;
  logic              wr_en;
  logic [PtrW-1:0]   wr_addr;
  logic [64:0]       wr_data;
  logic              out_load;

  logic [CntW-1:0]   lim;
  logic [CntW-1:0]   lim_m1;
  logic              pending_nz;
  logic [31:0]       cnt_inc;
  logic [PtrW+3:0]   head_ext;
  logic [3:0]        head_tag;

  // Clamp the configured limit into the usable range
  always_comb begin
    if (limit_i < 5'd2) begin
      lim = CntW'(2);
    end else if (int'(limit_i) > QueueDepth) begin
      lim = CntW'(QueueDepth);
    end else begin
      lim = CntW'(limit_i);
    end
  end

  assign lim_m1     = lim - CntW'(1);
  assign pending_nz = outst_q ? (slots_q > CntW'(1)) : (slots_q != '0);
  assign cnt_inc    = (skip_cnt_q == '1) ? skip_cnt_q : skip_cnt_q + 32'd1;
  assign head_ext   = {4'b0000, head_q};
  assign head_tag   = head_ext[3:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    last_addr_d = last_addr_q;
    slots_d     = slots_q;
    outst_d     = outst_q;
    last_kind_d = last_kind_q;
    skip_cnt_d  = skip_cnt_q;
    wr_en       = 1'b0;
    wr_addr     = tail_q;
    wr_data     = '0;
    cmd_pop_o   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_cpl) begin
            if (slots_q < lim_m1) begin
              wr_en       = 1'b1;
              wr_data     = {KIND_DATA, cmd_i.words};
              tail_d      = ptr_next(tail_q);
              slots_d     = slots_q + CntW'(1);
              last_kind_d = KIND_DATA;
              last_addr_d = tail_q;
              if (!outst_q) begin
                outst_d = 1'b1;
                state_d = BK_READ;
              end
            end else if (pending_nz && last_kind_q == KIND_SKIP) begin
              // Fold into the pending skip record at the tail
              wr_en      = 1'b1;
              wr_addr    = last_addr_q;
              wr_data    = {KIND_SKIP, 32'd0, cnt_inc};
              skip_cnt_d = cnt_inc;
            end else if (slots_q < lim) begin
              wr_en       = 1'b1;
              wr_data     = {KIND_SKIP, 32'd0, 32'd1};
              tail_d      = ptr_next(tail_q);
              slots_d     = slots_q + CntW'(1);
              last_kind_d = KIND_SKIP;
              last_addr_d = tail_q;
              skip_cnt_d  = 32'd1;
              if (!outst_q) begin
                outst_d = 1'b1;
                state_d = BK_READ;
              end
            end
          end else if (outst_q && slots_q != '0 && cmd_i.done_tag == head_tag) begin
            head_d  = ptr_next(head_q);
            slots_d = slots_q - CntW'(1);
            if (slots_q > CntW'(1)) begin
              state_d = BK_READ;
            end else begin
              outst_d = 1'b0;
            end
          end
        end
      end
      BK_READ: begin
        state_d = BK_LOAD;
      end
      BK_LOAD: begin
        if (!out_valid_q || pop_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      last_addr_q <= '0;
      slots_q     <= '0;
      outst_q     <= 1'b0;
      last_kind_q <= KIND_DATA;
      skip_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      last_addr_q <= last_addr_d;
      slots_q     <= slots_d;
      outst_q     <= outst_d;
      last_kind_q <= last_kind_d;
      skip_cnt_q  <= skip_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
  end

  // Read the new head in BK_READ, after its write has landed
  always_ff @(posedge clk_i) begin
    if (state_q == BK_READ) begin
      rd_data_q <= slot_mem_q[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.kind   <= rd_data_q[64];
      out_q.tag    <= head_tag;
      out_q.word_a <= rd_data_q[31:0];
      out_q.word_b <= rd_data_q[64] ? 32'd0 : rd_data_q[63:32];
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  `PPQSC_ASSERT(a_outst_iff_slots, (slots_q != '0) == outst_q, "outstanding flag out of step")
  `PPQSC_ASSERT_IMPL(a_load_fills, state_q == BK_LOAD && (!out_valid_q || pop_i), ##1 out_valid_q, "result not loaded")
  `PPQSC_ASSERT_IMPL(a_rise_from_load, $rose(out_valid_q), $past(state_q) == BK_LOAD, "result appeared outside load")

endmodule

// File: sim/ppqsc_delivery_checker.sv
`timescale 1ns / 1ps
module ppqsc_delivery_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 push_i,
  input  logic                 full_i,
  input  ppqsc_pkg::in_item_t  in_item_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  ppqsc_pkg::out_item_t out_item_i,
  output int                   awaiting_o,
  output int                   errors_o
);
  import ppqsc_pkg::*;

  localparam int unsigned Depth = 16;

  logic        slot_kind_q  [Depth];
  logic [63:0] slot_words_q [Depth];
  logic [3:0]  head_q;
  logic [3:0]  tail_q;
  logic [4:0]  used_q;
  logic        busy_q;
  logic [4:0]  limit_q;
  out_item_t   due_q [$];
  int          errors = 0;

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: delivery %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    errors++;
  endtask

  // Hand out the head slot as the one outstanding delivery.
  task automatic issue_head();
    out_item_t d;
    d.kind   = slot_kind_q[head_q];
    d.tag    = head_q;
    d.word_a = slot_words_q[head_q][31:0];
    d.word_b = (d.kind == KIND_SKIP) ? 32'd0 : slot_words_q[head_q][63:32];
    busy_q   = 1'b1;
    due_q.push_back(d);
  endtask

  task automatic append_slot(input logic kind, input logic [63:0] words);
    slot_kind_q[tail_q]  = kind;
    slot_words_q[tail_q] = words;
    tail_q = tail_q + 4'd1;
    used_q = used_q + 5'd1;
  endtask

  task automatic apply_event(input in_item_t it);
    logic [4:0] lim;
    logic [4:0] waiting;
    logic [3:0] last;
    lim = (limit_q < 5'd2) ? 5'd2 : (limit_q > Depth) ? 5'(Depth) : limit_q;
    if (it.command == CMD_PACKET) begin
      waiting = used_q - {4'd0, busy_q};
      if (used_q < lim - 5'd1) begin
        append_slot(KIND_DATA, {it.second_word, it.first_word});
        if (!busy_q) issue_head();
        return;
      end
      if (used_q > 0 && waiting > 0) begin
        last = tail_q - 4'd1;
        if (slot_kind_q[last] == KIND_SKIP) begin
          // Bump the pending skip record, saturating.
          if (slot_words_q[last][31:0] != 32'hFFFF_FFFF)
            slot_words_q[last] = {32'd0, slot_words_q[last][31:0] + 32'd1};
          return;
        end
      end
      if (used_q < lim) begin
        append_slot(KIND_SKIP, 64'd1);
        if (!busy_q) issue_head();
      end
      // otherwise drop silently
    end else begin
      if (!busy_q || used_q == 0) return;
      if (it.done_tag != head_q) return;
      head_q = head_q + 4'd1;
      used_q = used_q - 5'd1;
      busy_q = 1'b0;
      if (used_q > 0) issue_head();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      head_q  = '0;
      tail_q  = '0;
      used_q  = '0;
      busy_q  = 1'b0;
      limit_q = 5'd16;
      due_q.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected delivery, expected none, got %p", $time, out_item_i);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (out_item_i.kind !== want.kind)
            report("kind", 32'(want.kind), 32'(out_item_i.kind));
          if (out_item_i.tag !== want.tag)
            report("tag", 32'(want.tag), 32'(out_item_i.tag));
          if (out_item_i.word_a !== want.word_a)
            report("word_a", want.word_a, out_item_i.word_a);
          if (out_item_i.word_b !== want.word_b)
            report("word_b", want.word_b, out_item_i.word_b);
        end
      end
      if (push_i && !full_i) apply_event(in_item_i);
      if (cfg_we_i) limit_q = cfg_wdata_i;
    end
    awaiting_o <= due_q.size();
    errors_o   <= errors;
  end

endmodule

// File: sim/tb_phy_packet_queue_with_skip_count_unit.sv
`timescale 1ns / 1ps
module tb_phy_packet_queue_with_skip_count_unit;
  import ppqsc_pkg::*;

  localparam int ItemTarget  = 2000;
  localparam int DrainCycles = 20;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       push      = 1'b0;
  logic       pop       = 1'b0;
  in_item_t   in_item   = '0;
  logic       full;
  logic       empty;
  out_item_t  out_item;
  int         awaiting;
  int         errors;

  logic       steady     = 1'b0;
  logic [3:0] popped_tag = '0;
  int         pops_seen  = 0;
  int         pops_used  = 0;
  int         sent       = 0;

  always #5 clk = ~clk;

  phy_packet_queue_with_skip_count_unit #(
    .QUEUE_DEPTH(16)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item)
  );

  ppqsc_delivery_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push_i     (push),
    .full_i     (full),
    .in_item_i  (in_item),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_item_i (out_item),
    .awaiting_o (awaiting),
    .errors_o   (errors)
  );

  // Consumer side: random stalls, and note each delivered tag for completion.
  always @(posedge clk) begin
    if (rst_n) begin
      pop <= steady || ($urandom_range(99) >= 32);
      if (pop && !empty) begin
        popped_tag <= out_item.tag;
        pops_seen  <= pops_seen + 1;
      end
    end
  end

  initial begin
    #5ms;
    $display("phy_packet_queue_with_skip_count_unit test failed");
    $finish;
  end

  function automatic in_item_t mk_packet(input logic [31:0] a, input logic [31:0] b);
    in_item_t it;
    it.command     = CMD_PACKET;
    it.first_word  = a;
    it.second_word = b;
    it.done_tag    = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_completion(input logic [3:0] tag);
    in_item_t it;
    it.command     = CMD_COMPLETION;
    it.first_word  = $urandom;
    it.second_word = $urandom;
    it.done_tag    = tag;
    return it;
  endfunction

  // Hold the transaction until the queue takes it.
  task automatic send(input in_item_t it);
    while (!steady && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_limit(input logic [4:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int cpl_pct);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < cpl_pct && pops_seen != pops_used && $urandom_range(9) != 0) begin
        it = mk_completion(popped_tag);
        pops_used = pops_seen;
        sent++;
      end else if ($urandom_range(99) < cpl_pct / 4) begin
        it = mk_completion(4'($urandom));
      end else begin
        it = mk_packet($urandom, $urandom);
        sent++;
      end
      send(it);
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         len;
    logic [4:0] lim;
    logic [4:0] opening [7];
    opening = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd3};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk_completion(4'd0));                  // nothing outstanding yet
    send(mk_packet(32'h0000_0000, 32'h0000_0000));
    send(mk_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk_completion(4'd5));                  // tag does not match
    send(mk_completion(4'd0));
    set_limit(5'd2);
    send(mk_packet(32'hA5A5_A5A5, 32'h5A5A_5A5A)); // opens a skip record
    send(mk_packet(32'h5A5A_5A5A, 32'hA5A5_A5A5));
    send(mk_packet($urandom, $urandom));
    send(mk_completion(4'd1));
    send(mk_packet($urandom, $urandom));
    send(mk_completion(4'd2));
    send(mk_completion(4'd3));
    set_limit(5'd0);                            // below range, acts as two
    send(mk_packet($urandom, $urandom));
    send(mk_packet($urandom, $urandom));
    set_limit(5'd31);                           // above range, acts as full depth
    send(mk_completion(4'd4));
    send(mk_completion(4'd5));
    repeat (4) send(mk_packet($urandom, $urandom));
    // Shrink the limit under queued data so the next packet has no room at all.
    set_limit(5'd3);
    send(mk_packet($urandom, $urandom));

    phase = 0;
    while (sent < ItemTarget) begin
      lim = (phase < 7) ? opening[phase] : 5'($urandom_range(31));
      set_limit(lim);
      steady <= (phase == 3);
      len = (phase == 3) ? 300 : $urandom_range(60, 200);
      run_phase(len, 15 + 10 * $urandom_range(5));
      steady <= 1'b0;
      phase++;
    end
    settle();

    if (errors == 0) begin
      $display("phy_packet_queue_with_skip_count_unit test passed");
    end else begin
      $display("phy_packet_queue_with_skip_count_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ppqsc_pkg.sv
rtl/ppqsc_front.sv
rtl/ppqsc_back.sv
rtl/phy_packet_queue_with_skip_count_unit.sv
sim/ppqsc_delivery_checker.sv
sim/tb_phy_packet_queue_with_skip_count_unit.sv
